// ===== design/wbcvr_pkg.sv =====
// Shared types and constants for the write-back cache with victim reserve.
// Defines the request and result item structs and the function and kind codes.
// No dependencies.
`timescale 1ns / 1ps

package wbcvr_pkg;

    localparam int FIELD_ADDR_W = 24;
    localparam int FIELD_DATA_W = 64;

    localparam int DEF_INDEX_BITS    = 5;
    localparam int DEF_RESERVE_DEPTH = 16;
    localparam int DEF_ADDR_BITS     = 24;
    localparam int DEF_DATA_BITS     = 64;

    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_FILL   = 2'd2;
    localparam logic [1:0] FUNC_COMMIT = 2'd3;

    localparam logic [2:0] KIND_READ_DATA = 3'd0;
    localparam logic [2:0] KIND_READ_REQ  = 3'd1;
    localparam logic [2:0] KIND_WRITE     = 3'd2;
    localparam logic [2:0] KIND_COMMIT    = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    typedef struct packed {
        logic [1:0]              func;
        logic [FIELD_ADDR_W-1:0] addr;
        logic [FIELD_DATA_W-1:0] data;
    } req_item_t;

    typedef struct packed {
        logic [2:0]              kind;
        logic [FIELD_ADDR_W-1:0] out_addr;
        logic [FIELD_DATA_W-1:0] out_data;
        logic                    last;
    } rsp_item_t;

endpackage

// ===== design/write_back_cache_with_victim_reserve_core.sv =====
// Top level of the write-back cache with victim reserve and change log.
// Depends on wbcvr_pkg and wbcvr_ram.
`timescale 1ns / 1ps

// Direct-mapped write-back cache, one word per line, with a small victim reserve
// and a change log, all held in synchronous RAMs with registered read data.
// One item is worked at a time; req_stall is high while an item is in progress.
// A read miss or a write that misses walks the reserve one entry at a time (one
// RAM read, one compare) until the address is found or the filled entries run out;
// a read miss then gives its result. A commit reads each logged address and its line;
// an address not found in its line is searched for in the reserve. After the last
// logged address comes the commit marker.
// Each result waits in a single output register until rsp_stall is low; the next
// item is taken while the last result still waits there.
module write_back_cache_with_victim_reserve_core
    import wbcvr_pkg::*;
#(
    parameter int INDEX_BITS    = DEF_INDEX_BITS,
    parameter int RESERVE_DEPTH = DEF_RESERVE_DEPTH,
    parameter int ADDR_BITS     = DEF_ADDR_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int AW   = FIELD_ADDR_W;
    localparam int DW   = FIELD_DATA_W;
    localparam int NL   = 1 << INDEX_BITS;
    localparam int LD   = NL + RESERVE_DEPTH;
    localparam int TAGW = AW - INDEX_BITS;
    localparam int RIW  = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1;
    localparam int RCW  = $clog2(RESERVE_DEPTH + 1);
    localparam int LIW  = (LD > 1) ? $clog2(LD) : 1;
    localparam int LCW  = $clog2(LD + 1);
    localparam logic [AW-1:0] AMASK =
        (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [DW-1:0] DMASK =
        (DATA_BITS >= DW) ? {DW{1'b1}} : DW'((65'd1 << DATA_BITS) - 65'd1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_SREQ, ST_SCHK, ST_SDONE,
        ST_CREQ, ST_CLINE, ST_CHIT, ST_CNEXT, ST_EMIT
    } state_t;

    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [1:0]        func_reg, func_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [DW-1:0]     d_reg, d_next;
    logic              dirtyl_reg, dirtyl_next;
    logic [TAGW-1:0]   ltag_reg, ltag_next;
    logic [DW-1:0]     ldata_reg, ldata_next;
    logic [NL-1:0]     valid_reg, valid_next;
    logic [NL-1:0]     dirty_reg, dirty_next;
    logic [RCW-1:0]    rc_reg, rc_next;
    logic [LCW-1:0]    lc_reg, lc_next;
    logic              fp_reg, fp_next;
    logic [AW-1:0]     ft_reg, ft_next;
    logic [RCW-1:0]    si_reg, si_next;
    logic              found_reg, found_next;
    logic [RCW-1:0]    fidx_reg, fidx_next;
    logic [DW-1:0]     fdata_reg, fdata_next;
    logic [AW-1:0]     srch_reg, srch_next;
    logic [LCW-1:0]    ci_reg, ci_next;
    rsp_item_t         res_reg, res_next;
    logic              ov_reg, ov_next;
    rsp_item_t         ob_reg, ob_next;

    // line RAM: {tag, data}
    logic                     line_we;
    logic [INDEX_BITS-1:0]    line_waddr, line_raddr;
    logic [TAGW+DW-1:0]       line_wdata, line_rdata;
    logic [TAGW-1:0]          line_tag;
    logic [DW-1:0]            line_data;
    // reserve RAM: {addr, data}
    logic                     res_we;
    logic [RIW-1:0]           res_waddr, res_raddr;
    logic [AW+DW-1:0]         res_wdata, res_rdata;
    // change log RAM
    logic                     log_we;
    logic [LIW-1:0]           log_waddr, log_raddr;
    logic [AW-1:0]            log_wdata, log_rdata;

    logic [AW-1:0]            req_a;
    logic [AW-1:0]            tgt;
    logic [INDEX_BITS-1:0]    idx;
    logic                     hit;

    wbcvr_ram #(.WIDTH(TAGW + DW), .DEPTH(NL)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    wbcvr_ram #(.WIDTH(AW + DW), .DEPTH(RESERVE_DEPTH)) u_reserve_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    wbcvr_ram #(.WIDTH(AW), .DEPTH(LD)) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    assign line_tag  = line_rdata[TAGW+DW-1:DW];
    assign line_data = line_rdata[DW-1:0];
    assign req_a     = req.addr & AMASK;
    assign tgt       = (state_reg == ST_CHIT) ? srch_reg : a_reg;
    assign idx       = tgt[INDEX_BITS-1:0];
    assign hit       = valid_reg[idx] && (line_tag == tgt[AW-1:INDEX_BITS]);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = ob_reg;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        func_next   = func_reg;
        a_next      = a_reg;
        d_next      = d_reg;
        dirtyl_next = dirtyl_reg;
        ltag_next   = ltag_reg;
        ldata_next  = ldata_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        rc_next     = rc_reg;
        lc_next     = lc_reg;
        fp_next     = fp_reg;
        ft_next     = ft_reg;
        si_next     = si_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        fdata_next  = fdata_reg;
        srch_next   = srch_reg;
        ci_next     = ci_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        ob_next     = ob_reg;

        line_we    = 1'b0;
        line_waddr = a_reg[INDEX_BITS-1:0];
        line_wdata = {a_reg[AW-1:INDEX_BITS], d_reg};
        line_raddr = a_reg[INDEX_BITS-1:0];
        res_we     = 1'b0;
        res_waddr  = rc_reg[RIW-1:0];
        res_wdata  = {ltag_reg, a_reg[INDEX_BITS-1:0], ldata_reg};
        res_raddr  = si_reg[RIW-1:0];
        log_we     = 1'b0;
        log_waddr  = lc_reg[LIW-1:0];
        log_wdata  = a_reg;
        log_raddr  = ci_reg[LIW-1:0];

        // drain the output register
        if (ov_reg && !rsp_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next = req.func;
                    d_next    = req.data & DMASK;
                    if (req.func == FUNC_FILL)
                    begin
                        a_next     = ft_reg;
                        line_raddr = ft_reg[INDEX_BITS-1:0];
                        if (fp_reg)
                        begin
                            state_next = ST_LOOK;
                        end
                    end
                    else if (req.func == FUNC_COMMIT)
                    begin
                        ci_next = '0;
                        if (lc_reg != '0)
                        begin
                            state_next = ST_CREQ;
                        end
                    end
                    else
                    begin
                        a_next     = req_a;
                        line_raddr = req_a[INDEX_BITS-1:0];
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_LOOK:
            begin
                ltag_next   = line_tag;
                ldata_next  = line_data;
                dirtyl_next = dirty_reg[idx];
                srch_next   = a_reg;
                si_next     = '0;
                found_next  = 1'b0;
                ret_next    = ST_IDLE;
                case (func_reg)
                    FUNC_READ:
                    begin
                        if (hit)
                        begin
                            res_next   = '{KIND_READ_DATA, a_reg, line_data, 1'b1};
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_SREQ;
                        end
                    end
                    FUNC_WRITE:
                    begin
                        if (hit)
                        begin
                            if (!dirty_reg[idx] && lc_reg >= LCW'(LD))
                            begin
                                res_next   = '{KIND_ERROR, a_reg, '0, 1'b1};
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                if (!dirty_reg[idx])
                                begin
                                    log_we  = 1'b1;
                                    lc_next = lc_reg + 1'b1;
                                end
                                line_we         = 1'b1;
                                valid_next[idx] = 1'b1;
                                dirty_next[idx] = 1'b1;
                                state_next      = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_SREQ;
                        end
                    end
                    default:
                    begin
                        // fill: install only if the line still waits for this word
                        if (line_tag == a_reg[AW-1:INDEX_BITS] && !valid_reg[idx])
                        begin
                            line_we         = 1'b1;
                            valid_next[idx] = 1'b1;
                            dirty_next[idx] = 1'b0;
                        end
                        fp_next    = 1'b0;
                        res_next   = '{KIND_READ_DATA, a_reg, d_reg, 1'b1};
                        state_next = ST_EMIT;
                    end
                endcase
            end

            ST_SREQ:
            begin
                if (si_reg == rc_reg)
                begin
                    state_next = ST_SDONE;
                end
                else
                begin
                    state_next = ST_SCHK;
                end
            end

            ST_SCHK:
            begin
                if (res_rdata[AW+DW-1:DW] == srch_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = si_reg;
                    fdata_next = res_rdata[DW-1:0];
                    state_next = ST_SDONE;
                end
                else
                begin
                    si_next    = si_reg + 1'b1;
                    state_next = ST_SREQ;
                end
            end

            ST_SDONE:
            begin
                ret_next = ST_IDLE;
                case (func_reg)
                    FUNC_READ:
                    begin
                        state_next = ST_EMIT;
                        if (found_reg)
                        begin
                            res_next = '{KIND_READ_DATA, a_reg, fdata_reg, 1'b1};
                        end
                        else if (fp_reg || (dirtyl_reg && rc_reg >= RCW'(RESERVE_DEPTH)))
                        begin
                            res_next = '{KIND_ERROR, a_reg, '0, 1'b1};
                        end
                        else
                        begin
                            if (dirtyl_reg)
                            begin
                                res_we  = 1'b1;
                                rc_next = rc_reg + 1'b1;
                            end
                            line_we         = 1'b1;
                            valid_next[idx] = 1'b0;
                            dirty_next[idx] = 1'b0;
                            fp_next         = 1'b1;
                            ft_next         = a_reg;
                            res_next        = '{KIND_READ_REQ, a_reg, '0, 1'b1};
                        end
                    end
                    FUNC_WRITE:
                    begin
                        if (found_reg)
                        begin
                            res_we     = 1'b1;
                            res_waddr  = fidx_reg[RIW-1:0];
                            res_wdata  = {srch_reg, d_reg};
                            state_next = ST_IDLE;
                        end
                        else if (lc_reg >= LCW'(LD) ||
                                 (dirtyl_reg && rc_reg >= RCW'(RESERVE_DEPTH)))
                        begin
                            res_next   = '{KIND_ERROR, a_reg, '0, 1'b1};
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            if (dirtyl_reg)
                            begin
                                res_we  = 1'b1;
                                rc_next = rc_reg + 1'b1;
                            end
                            log_we          = 1'b1;
                            lc_next         = lc_reg + 1'b1;
                            line_we         = 1'b1;
                            valid_next[idx] = 1'b1;
                            dirty_next[idx] = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        res_next   = '{KIND_WRITE, srch_reg,
                                       found_reg ? fdata_reg : '0, 1'b0};
                        ret_next   = ST_CNEXT;
                        state_next = ST_EMIT;
                    end
                endcase
            end

            ST_CREQ:
            begin
                state_next = ST_CLINE;
            end

            ST_CLINE:
            begin
                srch_next  = log_rdata;
                line_raddr = log_rdata[INDEX_BITS-1:0];
                state_next = ST_CHIT;
            end

            ST_CHIT:
            begin
                si_next    = '0;
                found_next = 1'b0;
                if (hit)
                begin
                    res_next   = '{KIND_WRITE, srch_reg, line_data, 1'b0};
                    ret_next   = ST_CNEXT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SREQ;
                end
            end

            ST_CNEXT:
            begin
                ci_next = ci_reg + 1'b1;
                if (LCW'(ci_reg + 1'b1) == lc_reg)
                begin
                    dirty_next = '0;
                    lc_next    = '0;
                    rc_next    = '0;
                    res_next   = '{KIND_COMMIT, '0, '0, 1'b1};
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CREQ;
                end
            end

            ST_EMIT:
            begin
                if (!ov_reg || !rsp_stall)
                begin
                    ob_next    = res_reg;
                    ov_next    = 1'b1;
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            rc_reg    <= '0;
            lc_reg    <= '0;
            fp_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rc_reg    <= rc_next;
            lc_reg    <= lc_next;
            fp_reg    <= fp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        dirtyl_reg <= dirtyl_next;
        ltag_reg   <= ltag_next;
        ldata_reg  <= ldata_next;
        ft_reg     <= ft_next;
        si_reg     <= si_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        fdata_reg  <= fdata_next;
        srch_reg   <= srch_next;
        ci_reg     <= ci_next;
        res_reg    <= res_next;
        ob_reg     <= ob_next;
    end

    a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RCW'(RESERVE_DEPTH))
        else $error("reserve count past depth");

    a_lc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= LCW'(LD))
        else $error("log count past depth");

    a_srch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCHK) |-> (si_reg < rc_reg))
        else $error("reserve search beyond filled entries");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_reg.kind == KIND_COMMIT) |-> (lc_reg == '0 && rc_reg == '0))
        else $error("commit marker with log or reserve not cleared");

endmodule

// ===== design/wbcvr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module wbcvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
